>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion shorthands shared by the console RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Condition must hold at every clock edge outside reset.
`define TCW_ASSERT_ALWAYS(label, clk, rst, cond, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error(msg);

// Antecedent at one edge implies consequent at the next edge.
`define TCW_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> sv/tcw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_pkg
// Types, field widths and character codes of the text console cell writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

   localparam int CMD_W    = 2;
   localparam int CHAR_W   = 8;
   localparam int COLUMN_W = 7;
   localparam int LINE_W   = 5;
   localparam int CURSOR_W = 11;
   localparam int CELL_W   = 16;
   localparam int ATTR_W   = 8;

   localparam logic [CMD_W-1:0] CMD_PUT   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_SET   = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR = 2'd2;
   localparam logic [CMD_W-1:0] CMD_READ  = 2'd3;

   localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'd10;
   localparam logic [CHAR_W-1:0] CH_RETURN    = 8'd13;
   localparam logic [CHAR_W-1:0] CH_TAB       = 8'd9;
   localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'd8;
   localparam logic [CHAR_W-1:0] BLANK_CHAR   = 8'h20;

   localparam logic [ATTR_W-1:0] RESET_ATTR = 8'd7;
   localparam logic [ATTR_W-1:0] ZERO_ATTR  = 8'd0;

   typedef enum logic [2:0] {
      K_PRINT,
      K_NEWLINE,
      K_RETURN,
      K_TAB,
      K_BACKSPACE,
      K_SET,
      K_CLEAR,
      K_READ
   } tcw_kind_type;

   typedef struct packed {
      tcw_kind_type        kind;
      logic [CHAR_W-1:0]   char_code;
      logic [COLUMN_W-1:0] column;
      logic [LINE_W-1:0]   line;
   } tcw_op_type;

   typedef enum logic [2:0] {
      ST_INIT,
      ST_IDLE,
      ST_READ,
      ST_CLEAR,
      ST_COPY,
      ST_FILL,
      ST_PUT,
      ST_TAB
   } tcw_state_type;

endpackage

>>> sv/tcw_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_if
// Command and result channels of the text console cell writer.
// ----------------------------------------------------------------------------
interface tcw_req_if;
   import tcw_pkg::*;

   logic                valid;
   logic                ready;
   logic [CMD_W-1:0]    cmd;
   logic [CHAR_W-1:0]   char_code;
   logic [COLUMN_W-1:0] column;
   logic [LINE_W-1:0]   line;

   modport source (output valid, output cmd, output char_code, output column,
                   output line, input ready);
   modport sink   (input valid, input cmd, input char_code, input column,
                   input line, output ready);
endinterface

interface tcw_rsp_if;
   import tcw_pkg::*;

   logic                valid;
   logic                ready;
   logic [CURSOR_W-1:0] cursor_pos;
   logic [CELL_W-1:0]   cell_data;
   logic                scrolled;

   modport source (output valid, output cursor_pos, output cell_data,
                   output scrolled, input ready);
   modport sink   (input valid, input cursor_pos, input cell_data,
                   input scrolled, output ready);
endinterface

>>> sv/text_console_cell_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_console_cell_writer
// Text console engine: screen store of attribute/character cells and cursor.
// ----------------------------------------------------------------------------
//   channel  dir  handshake           payload
//   req_if   in   valid/ready         cmd, char_code, column, line
//   rsp_if   out  valid/ready         cursor_pos, cell_data, scrolled
//   csr_*    in   csr_wr_en (1 cycle) csr_wr_data = text attribute
//
// Set cursor, return, newline, backspace and printable finish as they leave
// the queue unless they scroll; read cell adds a read state, tab a tab state
// that writes the blanks. A scroll walks the screen store through its single
// write port, copying rows up, then blanking the bottom row; clear blanks the
// store. The decode front is combinational; the queue registers words. After
// reset the store is swept to blanks with req_if.ready low. A stalled result
// holds in the output register while up to QUEUE_DEPTH further words are taken.
// ----------------------------------------------------------------------------
module text_console_cell_writer #(
   parameter int COLUMNS     = 80,
   parameter int ROWS        = 25,
   parameter int TAB_STOP    = 8,
   parameter int QUEUE_DEPTH = 2
) (
   input  logic                       clock,
   input  logic                       reset,
   tcw_req_if.sink                    req_if,
   tcw_rsp_if.source                  rsp_if,
   input  logic                       csr_wr_en,
   input  logic [tcw_pkg::ATTR_W-1:0] csr_wr_data
);
   import tcw_pkg::*;

   logic [ATTR_W-1:0] attr_ff, attr_in;
   logic              busy;
   logic              push_valid, push_ready;
   tcw_op_type        push_data;
   logic              pop_valid, pop_ready;
   tcw_op_type        pop_data;

   assign attr_in = csr_wr_en ? csr_wr_data : attr_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         attr_ff <= RESET_ATTR;
      end else begin
         attr_ff <= attr_in;
      end
   end

   tcw_front u_front (
      .req_if     (req_if),
      .busy       (busy),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   tcw_fifo #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   tcw_back #(
      .COLUMNS  (COLUMNS),
      .ROWS     (ROWS),
      .TAB_STOP (TAB_STOP)
   ) u_back (
      .clock          (clock),
      .reset          (reset),
      .text_attribute (attr_ff),
      .op_valid       (pop_valid),
      .op_data        (pop_data),
      .op_pop         (pop_ready),
      .busy           (busy),
      .rsp_if         (rsp_if)
   );

endmodule

>>> sv/tcw_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module tcw_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 2000
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/tcw_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_fifo
// Short command queue between the decode front and the execution back.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcw_fifo #(
   parameter int DEPTH = 2
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                push_valid,
   output logic                push_ready,
   input  tcw_pkg::tcw_op_type push_data,
   output logic                pop_valid,
   input  logic                pop_ready,
   output tcw_pkg::tcw_op_type pop_data
);
   import tcw_pkg::*;

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int NW = $clog2(DEPTH + 1);

   tcw_op_type     slot_ff [DEPTH];
   logic [PW-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [NW-1:0]  count_ff, count_in;
   logic           do_push, do_pop;

   assign push_ready = (count_ff != NW'(DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PW'(DEPTH - 1)) ? '0 : wr_ptr_ff + PW'(1);
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PW'(DEPTH - 1)) ? '0 : rd_ptr_ff + PW'(1);
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + NW'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - NW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   `TCW_ASSERT_ALWAYS(a_fifo_count, clock, reset, count_ff <= NW'(DEPTH), "queue overfilled")

endmodule

>>> sv/tcw_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_front
// Accepts command words and classifies them into console operations.
// ----------------------------------------------------------------------------
module tcw_front (
   tcw_req_if.sink             req_if,
   input  logic                busy,
   output logic                push_valid,
   input  logic                push_ready,
   output tcw_pkg::tcw_op_type push_data
);
   import tcw_pkg::*;

   tcw_kind_type kind;

   // hold off while the screen store is being swept after reset
   assign req_if.ready = push_ready && !busy;
   assign push_valid   = req_if.valid && !busy;

   always_comb begin
      unique case (req_if.cmd)
         CMD_PUT: begin
            unique case (req_if.char_code)
               CH_NEWLINE:   kind = K_NEWLINE;
               CH_RETURN:    kind = K_RETURN;
               CH_TAB:       kind = K_TAB;
               CH_BACKSPACE: kind = K_BACKSPACE;
               default:      kind = K_PRINT;
            endcase
         end
         CMD_SET:   kind = K_SET;
         CMD_CLEAR: kind = K_CLEAR;
         CMD_READ:  kind = K_READ;
         default:   kind = K_READ;
      endcase
   end

   always_comb begin
      push_data.kind      = kind;
      push_data.char_code = req_if.char_code;
      push_data.column    = req_if.column;
      push_data.line      = req_if.line;
   end

endmodule

>>> sv/tcw_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tcw_back
// Executes console operations on the screen store and registers the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module tcw_back #(
   parameter int COLUMNS  = 80,
   parameter int ROWS     = 25,
   parameter int TAB_STOP = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [tcw_pkg::ATTR_W-1:0]  text_attribute,
   input  logic                        op_valid,
   input  tcw_pkg::tcw_op_type         op_data,
   output logic                        op_pop,
   output logic                        busy,
   tcw_rsp_if.source                   rsp_if
);
   import tcw_pkg::*;

   localparam int CELLS = COLUMNS * ROWS;
   localparam int AW    = $clog2(CELLS);
   localparam int LW    = $clog2(CELLS + 1);
   localparam int RW    = $clog2(ROWS + 1);
   localparam int CW    = $clog2(COLUMNS);
   localparam int TW    = $clog2(TAB_STOP + 1);
   localparam int CCW   = (CW > COLUMN_W) ? CW : COLUMN_W;
   localparam int RCW   = (RW > LINE_W) ? RW : LINE_W;

   localparam logic [LW-1:0] END_LIN   = LW'(CELLS);
   localparam logic [LW-1:0] COPY_N    = LW'(CELLS - COLUMNS);
   localparam logic [LW-1:0] LAST_CELL = LW'(CELLS - 1);

   tcw_state_type       state_ff, state_in;
   tcw_op_type          op_ff, op_in;
   logic [LW-1:0]       lin_ff, lin_in;
   logic [RW-1:0]       row_ff, row_in;
   logic [CW-1:0]       col_ff, col_in;
   logic [LW-1:0]       ctr_ff, ctr_in;
   logic [TW-1:0]       tab_left_ff, tab_left_in;
   logic                scrolled_ff, scrolled_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [CURSOR_W-1:0] rsp_cursor_ff, rsp_cursor_in;
   logic [CELL_W-1:0]   rsp_cell_ff, rsp_cell_in;
   logic                rsp_scrolled_ff, rsp_scrolled_in;

   logic                wr_en, rd_en;
   logic [AW-1:0]       wr_addr, rd_addr;
   logic [CELL_W-1:0]   wr_data, rd_data;

   logic                pop_ok, at_end, last_row, ctr_last, copy_done, tab_last;
   logic                finish;
   logic [CELL_W-1:0]   cell_out;
   logic [CW-1:0]       sat_col, adv_col;
   logic [RW-1:0]       sat_row, adv_row;
   logic [LW-1:0]       sat_lin;
   logic [CELL_W-1:0]   blank_cell;
   logic [TW-1:0]       phase_rom [2**CW];

   for (genvar g = 0; g < 2**CW; g++) begin : g_phase
      assign phase_rom[g] = TW'(g % TAB_STOP);
   end

   tcw_ram #(
      .WIDTH (CELL_W),
      .DEPTH (CELLS)
   ) u_screen (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign pop_ok     = (state_ff == ST_IDLE) && op_valid && !rsp_valid_ff;
   assign at_end     = (lin_ff == END_LIN);
   assign last_row   = (row_ff >= RW'(ROWS - 1));
   assign ctr_last   = (ctr_ff == LAST_CELL);
   assign copy_done  = (ctr_ff == COPY_N);
   assign tab_last   = (tab_left_ff == TW'(1));
   assign busy       = (state_ff == ST_INIT);
   assign blank_cell = {text_attribute, BLANK_CHAR};

   assign sat_col = (CCW'(op_data.column) > CCW'(COLUMNS - 1)) ? CW'(COLUMNS - 1)
                                                                : CW'(op_data.column);
   assign sat_row = (RCW'(op_data.line) > RCW'(ROWS - 1)) ? RW'(ROWS - 1)
                                                          : RW'(op_data.line);
   assign sat_lin = LW'(sat_row) * LW'(COLUMNS) + LW'(sat_col);

   assign adv_col = (col_ff == CW'(COLUMNS - 1)) ? '0 : col_ff + CW'(1);
   assign adv_row = (col_ff == CW'(COLUMNS - 1)) ? row_ff + RW'(1) : row_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            if (ctr_last) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (pop_ok) begin
               case (op_data.kind)
                  K_READ:    state_in = ST_READ;
                  K_CLEAR:   state_in = ST_CLEAR;
                  K_TAB:     state_in = ST_TAB;
                  K_NEWLINE: state_in = last_row ? ST_COPY : ST_IDLE;
                  K_PRINT:   state_in = at_end ? ST_COPY : ST_IDLE;
                  default:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_READ: state_in = ST_IDLE;
         ST_COPY: begin
            if (copy_done) begin
               state_in = ST_FILL;
            end
         end
         ST_FILL: begin
            if (ctr_last) begin
               case (op_ff.kind)
                  K_PRINT: state_in = ST_PUT;
                  K_TAB:   state_in = ST_TAB;
                  default: state_in = ST_IDLE;
               endcase
            end
         end
         ST_PUT: state_in = ST_IDLE;
         ST_TAB: begin
            if (at_end) begin
               state_in = ST_COPY;
            end else if (tab_last) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // datapath and store access
   always_comb begin
      op_in           = op_ff;
      lin_in          = lin_ff;
      row_in          = row_ff;
      col_in          = col_ff;
      ctr_in          = ctr_ff;
      tab_left_in     = tab_left_ff;
      scrolled_in     = scrolled_ff;
      op_pop          = 1'b0;
      finish          = 1'b0;
      cell_out        = '0;
      wr_en           = 1'b0;
      wr_addr         = '0;
      wr_data         = '0;
      rd_en           = 1'b0;
      rd_addr         = '0;

      unique case (state_ff)
         ST_INIT, ST_CLEAR: begin
            wr_en   = 1'b1;
            wr_addr = AW'(ctr_ff);
            wr_data = {ZERO_ATTR, BLANK_CHAR};
            ctr_in  = ctr_ff + LW'(1);
            if (ctr_last) begin
               ctr_in = '0;
               lin_in = '0;
               row_in = '0;
               col_in = '0;
               finish = (state_ff == ST_CLEAR);
            end
         end
         ST_IDLE: begin
            if (pop_ok) begin
               op_pop      = 1'b1;
               op_in       = op_data;
               scrolled_in = 1'b0;
               ctr_in      = '0;
               case (op_data.kind)
                  K_SET: begin
                     lin_in = sat_lin;
                     row_in = sat_row;
                     col_in = sat_col;
                     finish = 1'b1;
                  end
                  K_READ: begin
                     rd_en   = 1'b1;
                     rd_addr = AW'(sat_lin);
                  end
                  K_RETURN: begin
                     lin_in = lin_ff - LW'(col_ff);
                     col_in = '0;
                     finish = 1'b1;
                  end
                  K_NEWLINE: begin
                     if (!last_row) begin
                        lin_in = lin_ff - LW'(col_ff) + LW'(COLUMNS);
                        row_in = row_ff + RW'(1);
                        col_in = '0;
                        finish = 1'b1;
                     end
                  end
                  K_BACKSPACE: begin
                     if (lin_ff != '0) begin
                        lin_in  = lin_ff - LW'(1);
                        wr_en   = 1'b1;
                        wr_addr = AW'(lin_ff - LW'(1));
                        wr_data = blank_cell;
                        if (col_ff == '0) begin
                           col_in = CW'(COLUMNS - 1);
                           row_in = row_ff - RW'(1);
                        end else begin
                           col_in = col_ff - CW'(1);
                        end
                     end
                     finish = 1'b1;
                  end
                  K_PRINT: begin
                     if (!at_end) begin
                        wr_en   = 1'b1;
                        wr_addr = AW'(lin_ff);
                        wr_data = {text_attribute, op_data.char_code};
                        lin_in  = lin_ff + LW'(1);
                        row_in  = adv_row;
                        col_in  = adv_col;
                        finish  = 1'b1;
                     end
                  end
                  K_TAB: begin
                     tab_left_in = TW'(TAB_STOP) - phase_rom[col_ff];
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_READ: begin
            cell_out = rd_data;
            finish   = 1'b1;
         end
         ST_COPY: begin
            // read one row ahead, write the word read last cycle
            if (!copy_done) begin
               rd_en   = 1'b1;
               rd_addr = AW'(ctr_ff + LW'(COLUMNS));
               ctr_in  = ctr_ff + LW'(1);
            end
            if (ctr_ff != '0) begin
               wr_en   = 1'b1;
               wr_addr = AW'(ctr_ff - LW'(1));
               wr_data = rd_data;
            end
         end
         ST_FILL: begin
            wr_en   = 1'b1;
            wr_addr = AW'(ctr_ff);
            wr_data = blank_cell;
            ctr_in  = ctr_ff + LW'(1);
            if (ctr_last) begin
               ctr_in      = '0;
               lin_in      = COPY_N;
               row_in      = RW'(ROWS - 1);
               col_in      = '0;
               scrolled_in = 1'b1;
               finish      = (op_ff.kind != K_PRINT) && (op_ff.kind != K_TAB);
            end
         end
         ST_PUT: begin
            wr_en   = 1'b1;
            wr_addr = AW'(lin_ff);
            wr_data = {text_attribute, op_ff.char_code};
            lin_in  = lin_ff + LW'(1);
            row_in  = adv_row;
            col_in  = adv_col;
            finish  = 1'b1;
         end
         ST_TAB: begin
            if (!at_end) begin
               wr_en       = 1'b1;
               wr_addr     = AW'(lin_ff);
               wr_data     = blank_cell;
               lin_in      = lin_ff + LW'(1);
               row_in      = adv_row;
               col_in      = adv_col;
               tab_left_in = tab_left_ff - TW'(1);
               finish      = tab_last;
            end
         end
         default: begin
         end
      endcase
   end

   // result register
   always_comb begin
      rsp_valid_in    = rsp_valid_ff;
      rsp_cursor_in   = rsp_cursor_ff;
      rsp_cell_in     = rsp_cell_ff;
      rsp_scrolled_in = rsp_scrolled_ff;
      if (rsp_if.valid && rsp_if.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (finish) begin
         rsp_valid_in    = 1'b1;
         rsp_cursor_in   = CURSOR_W'(lin_in);
         rsp_cell_in     = cell_out;
         rsp_scrolled_in = scrolled_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_INIT;
         lin_ff       <= '0;
         row_ff       <= '0;
         col_ff       <= '0;
         ctr_ff       <= '0;
         tab_left_ff  <= '0;
         scrolled_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         lin_ff       <= lin_in;
         row_ff       <= row_in;
         col_ff       <= col_in;
         ctr_ff       <= ctr_in;
         tab_left_ff  <= tab_left_in;
         scrolled_ff  <= scrolled_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff           <= op_in;
      rsp_cursor_ff   <= rsp_cursor_in;
      rsp_cell_ff     <= rsp_cell_in;
      rsp_scrolled_ff <= rsp_scrolled_in;
   end

   assign rsp_if.valid      = rsp_valid_ff;
   assign rsp_if.cursor_pos = rsp_cursor_ff;
   assign rsp_if.cell_data  = rsp_cell_ff;
   assign rsp_if.scrolled   = rsp_scrolled_ff;

   `TCW_ASSERT_ALWAYS(a_cursor_range, clock, reset, lin_ff <= END_LIN,
      "cursor past end of screen")
   `TCW_ASSERT_ALWAYS(a_cursor_split, clock, reset,
      lin_ff == LW'(row_ff) * LW'(COLUMNS) + LW'(col_ff), "cursor row/column mismatch")
   `TCW_ASSERT_NEXT(a_scroll_home, clock, reset, (state_ff == ST_FILL) && ctr_last,
      (lin_ff == COPY_N) && scrolled_ff, "scroll did not home cursor to bottom row")

endmodule

>>> dv/tb_text_console_cell_writer.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_text_console_cell_writer
// Self-checking bench for the text console cell writer. A clocked driver
// feeds command words from a backlog, and an in-bench console image of the
// screen store, cursor and attribute forecasts each reply. A clocked monitor
// checks every reply word field by field. Attribute writes happen only
// between phases, with the block idle.
// ----------------------------------------------------------------------------
module tb_text_console_cell_writer;
   import tcw_pkg::*;

   localparam int COLUMNS       = 80;
   localparam int ROWS          = 25;
   localparam int TAB_STOP      = 8;
   localparam int CELL_COUNT    = ROWS * COLUMNS;
   localparam int PHASE_WORDS   = 285;
   localparam int HOLD_CYCLES   = 400;
   localparam int MAX_REPORTS   = 100;
   localparam int LIMIT_CYCLES  = 20000000;

   typedef struct packed {
      logic [CMD_W-1:0]    cmd;
      logic [CHAR_W-1:0]   char_code;
      logic [COLUMN_W-1:0] column;
      logic [LINE_W-1:0]   line;
   } console_word_type;

   typedef struct packed {
      logic [CURSOR_W-1:0] cursor_pos;
      logic [CELL_W-1:0]   cell_data;
      logic                scrolled;
   } console_reply_type;

   logic              clock;
   logic              reset;
   logic              csr_wr_en;
   logic [ATTR_W-1:0] csr_wr_data;

   tcw_req_if req_bus ();
   tcw_rsp_if rsp_bus ();

   text_console_cell_writer dut (
      .clock       (clock),
      .reset       (reset),
      .req_if      (req_bus),
      .rsp_if      (rsp_bus),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   // console image
   logic [CELL_W-1:0] screen_image [CELL_COUNT];
   int unsigned       cursor_image;
   logic [ATTR_W-1:0] attr_image;

   console_word_type  cmd_backlog [$];
   console_reply_type expected_replies [$];

   int unsigned mismatch_count;
   int unsigned send_gap, send_quiet;
   int unsigned recv_gap, recv_quiet;
   int unsigned hold_left, hold_served, hold_requests;
   logic [COLUMN_W-1:0] burst_col;
   logic [LINE_W-1:0]   burst_line;

   always #6 clock = ~clock;

   function automatic logic [CELL_W-1:0] blank_cell();
      return {attr_image, BLANK_CHAR};
   endfunction

   function automatic void wipe_screen();
      for (int i = 0; i < CELL_COUNT; i++) screen_image[i] = {ZERO_ATTR, BLANK_CHAR};
      cursor_image = 0;
   endfunction

   function automatic void scroll_up();
      for (int i = 0; i < CELL_COUNT - COLUMNS; i++) screen_image[i] = screen_image[i + COLUMNS];
      for (int i = CELL_COUNT - COLUMNS; i < CELL_COUNT; i++) screen_image[i] = blank_cell();
      cursor_image = CELL_COUNT - COLUMNS;
   endfunction

   function automatic int unsigned clamp_index(logic [COLUMN_W-1:0] col,
                                               logic [LINE_W-1:0] ln);
      int unsigned c, r;
      c = (col >= COLUMNS) ? COLUMNS - 1 : col;
      r = (ln >= ROWS) ? ROWS - 1 : ln;
      return r * COLUMNS + c;
   endfunction

   function automatic console_reply_type emulate_console_cmd(console_word_type w);
      console_reply_type rep;
      int unsigned       row, n;
      rep = '0;
      case (w.cmd)
         CMD_PUT: begin
            case (w.char_code)
               CH_NEWLINE: begin
                  row = cursor_image / COLUMNS + 1;
                  if (row >= ROWS) begin
                     scroll_up();
                     rep.scrolled = 1'b1;
                     row = ROWS - 1;
                  end
                  cursor_image = row * COLUMNS;
               end
               CH_RETURN: cursor_image = cursor_image - cursor_image % COLUMNS;
               CH_TAB: begin
                  n = TAB_STOP - (cursor_image % COLUMNS) % TAB_STOP;
                  for (int k = 0; k < n; k++) begin
                     if (cursor_image >= CELL_COUNT) begin
                        scroll_up();
                        rep.scrolled = 1'b1;
                     end
                     screen_image[cursor_image] = blank_cell();
                     cursor_image++;
                  end
               end
               CH_BACKSPACE: begin
                  if (cursor_image != 0) begin
                     cursor_image--;
                     screen_image[cursor_image] = blank_cell();
                  end
               end
               default: begin
                  // scroll before writing past the last cell
                  if (cursor_image >= CELL_COUNT) begin
                     scroll_up();
                     rep.scrolled = 1'b1;
                  end
                  screen_image[cursor_image] = {attr_image, w.char_code};
                  cursor_image++;
               end
            endcase
         end
         CMD_SET:   cursor_image = clamp_index(w.column, w.line);
         CMD_CLEAR: wipe_screen();
         default:   rep.cell_data = screen_image[clamp_index(w.column, w.line)];
      endcase
      rep.cursor_pos = CURSOR_W'(cursor_image);
      return rep;
   endfunction

   function automatic int unsigned pick_gap();
      if ($urandom_range(0, 9) == 0) return $urandom_range(8, 40);
      return $urandom_range(1, 3);
   endfunction

   function automatic logic [CHAR_W-1:0] pick_printable();
      logic [CHAR_W-1:0] c;
      if ($urandom_range(0, 9) < 7) return CHAR_W'($urandom_range(8'h20, 8'h7E));
      do c = CHAR_W'($urandom_range(0, 255));
      while (c == CH_NEWLINE || c == CH_RETURN || c == CH_TAB || c == CH_BACKSPACE);
      return c;
   endfunction

   function automatic logic [CHAR_W-1:0] pick_put_char(int unsigned tab_pct,
                                                      int unsigned nl_pct);
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < tab_pct) return CH_TAB;
      if (r < tab_pct + nl_pct) return CH_NEWLINE;
      if (r < tab_pct + nl_pct + 3) return CH_RETURN;
      if (r < tab_pct + nl_pct + 6) return CH_BACKSPACE;
      return pick_printable();
   endfunction

   task automatic queue_cmd(logic [CMD_W-1:0] c, logic [CHAR_W-1:0] ch,
                            logic [COLUMN_W-1:0] col, logic [LINE_W-1:0] ln);
      console_word_type w;
      w.cmd       = c;
      w.char_code = ch;
      w.column    = col;
      w.line      = ln;
      cmd_backlog.push_back(w);
   endtask

   task automatic queue_random_burst();
      int unsigned      r, n;
      logic [CMD_W-1:0] c;
      r = $urandom_range(0, 99);
      if (r < 45) begin
         // line of text at a random spot
         burst_col  = ($urandom_range(0, 9) == 0) ? COLUMN_W'($urandom_range(0, 127))
                                                  : COLUMN_W'($urandom_range(0, 79));
         burst_line = ($urandom_range(0, 9) == 0) ? LINE_W'($urandom_range(0, 31))
                                                  : LINE_W'($urandom_range(0, 24));
         queue_cmd(CMD_SET, pick_printable(), burst_col, burst_line);
         n = $urandom_range(4, 16);
         repeat (n) queue_cmd(CMD_PUT, pick_put_char(4, 5), COLUMN_W'($urandom),
                              LINE_W'($urandom));
      end else if (r < 57) begin
         // run off the end of the screen
         burst_col  = ($urandom_range(0, 4) == 0) ? COLUMN_W'($urandom_range(80, 127))
                                                  : COLUMN_W'($urandom_range(72, 79));
         burst_line = ($urandom_range(0, 9) < 7) ? LINE_W'(24)
                                                 : LINE_W'($urandom_range(25, 31));
         queue_cmd(CMD_SET, 0, burst_col, burst_line);
         n = $urandom_range(4, 12);
         repeat (n) queue_cmd(CMD_PUT, pick_put_char(15, 10), COLUMN_W'($urandom),
                              LINE_W'($urandom));
      end else if (r < 75) begin
         // read back around the last text
         n = $urandom_range(2, 8);
         for (int k = 0; k < n; k++) begin
            if ($urandom_range(0, 4) == 0)
               queue_cmd(CMD_READ, CHAR_W'($urandom), COLUMN_W'($urandom_range(0, 79)),
                         LINE_W'($urandom_range(0, 24)));
            else
               queue_cmd(CMD_READ, CHAR_W'($urandom), COLUMN_W'(burst_col + k),
                         burst_line);
         end
      end else if (r < 85) begin
         // back up into the origin
         queue_cmd(CMD_SET, 0, COLUMN_W'($urandom_range(0, 3)), 0);
         n = $urandom_range(3, 6);
         repeat (n) queue_cmd(CMD_PUT, CH_BACKSPACE, COLUMN_W'($urandom),
                              LINE_W'($urandom));
         queue_cmd(CMD_PUT, pick_printable(), 0, 0);
         queue_cmd(CMD_READ, 0, 0, 0);
      end else if (r < 87) begin
         queue_cmd(CMD_CLEAR, CHAR_W'($urandom), COLUMN_W'($urandom), LINE_W'($urandom));
         queue_cmd(CMD_READ, 0, burst_col, burst_line);
      end else if (r < 95) begin
         // noise over the full field ranges, clears thinned out
         n = $urandom_range(1, 3);
         repeat (n) begin
            c = CMD_W'($urandom_range(0, 3));
            if (c == CMD_CLEAR && $urandom_range(0, 2) != 0) c = CMD_READ;
            queue_cmd(c, CHAR_W'($urandom), COLUMN_W'($urandom), LINE_W'($urandom));
         end
      end else begin
         queue_cmd(($urandom_range(0, 1) == 0) ? CMD_SET : CMD_READ, CHAR_W'($urandom),
                   COLUMN_W'($urandom_range(0, 127)), LINE_W'($urandom_range(0, 31)));
      end
   endtask

   task automatic wait_console_idle();
      do @(negedge clock);
      while (cmd_backlog.size() != 0 || req_bus.valid || expected_replies.size() != 0);
   endtask

   task automatic set_text_attribute(logic [ATTR_W-1:0] a);
      wait_console_idle();
      repeat (4) @(posedge clock);
      csr_wr_en   <= 1'b1;
      csr_wr_data <= a;
      attr_image = a;
      @(posedge clock);
      csr_wr_en <= 1'b0;
      repeat (2) @(posedge clock);
      @(negedge clock);
   endtask

   // command driver
   always @(posedge clock) begin : cmd_driver
      console_word_type w;
      if (reset) begin
         req_bus.valid <= 1'b0;
         send_gap   = 0;
         send_quiet = 0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            w.cmd       = req_bus.cmd;
            w.char_code = req_bus.char_code;
            w.column    = req_bus.column;
            w.line      = req_bus.line;
            expected_replies.push_back(emulate_console_cmd(w));
         end
         // hold the word until it is taken
         if (!(req_bus.valid && !req_bus.ready)) begin
            if (send_gap != 0) begin
               send_gap--;
               req_bus.valid <= 1'b0;
            end else if (cmd_backlog.size() != 0) begin
               w = cmd_backlog.pop_front();
               req_bus.cmd       <= w.cmd;
               req_bus.char_code <= w.char_code;
               req_bus.column    <= w.column;
               req_bus.line      <= w.line;
               req_bus.valid     <= 1'b1;
               if (send_quiet != 0) send_quiet--;
               else if ($urandom_range(0, 39) == 0) send_quiet = $urandom_range(20, 80);
               else if ($urandom_range(0, 3) == 0) send_gap = pick_gap();
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off, so the block backs up and stalls its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left   <= 0;
         hold_served <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (hold_served < hold_requests) begin
         hold_left   <= HOLD_CYCLES;
         hold_served <= hold_served + 1;
      end
   end

   // reply monitor
   always @(posedge clock) begin : reply_monitor
      console_reply_type want;
      if (reset) begin
         rsp_bus.ready <= 1'b0;
         recv_gap   = 0;
         recv_quiet = 0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (expected_replies.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS)
                  $error("reply word with no command outstanding");
            end else begin
               want = expected_replies.pop_front();
               if (rsp_bus.cursor_pos !== want.cursor_pos) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $error("cursor_pos expected %0d actual %0d",
                            want.cursor_pos, rsp_bus.cursor_pos);
               end
               if (rsp_bus.cell_data !== want.cell_data) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $error("cell_data expected %h actual %h",
                            want.cell_data, rsp_bus.cell_data);
               end
               if (rsp_bus.scrolled !== want.scrolled) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS)
                     $error("scrolled expected %0b actual %0b",
                            want.scrolled, rsp_bus.scrolled);
               end
            end
         end
         if (hold_left != 0) begin
            rsp_bus.ready <= 1'b0;
         end else if (recv_gap != 0) begin
            recv_gap--;
            rsp_bus.ready <= 1'b0;
         end else begin
            rsp_bus.ready <= 1'b1;
            if (recv_quiet != 0) recv_quiet--;
            else if ($urandom_range(0, 49) == 0) recv_quiet = $urandom_range(20, 80);
            else if ($urandom_range(0, 4) == 0) recv_gap = pick_gap();
         end
      end
   end

   initial begin : watchdog
      int unsigned cycles;
      for (cycles = 0; cycles < LIMIT_CYCLES; cycles++) @(posedge clock);
      $display("text_console_cell_writer verification failed");
      $finish;
   end

   initial begin : stimulus
      logic [ATTR_W-1:0] phase_attr [6];
      clock             = 1'b0;
      reset             = 1'b1;
      csr_wr_en         = 1'b0;
      csr_wr_data       = '0;
      req_bus.valid     = 1'b0;
      req_bus.cmd       = CMD_PUT;
      req_bus.char_code = '0;
      req_bus.column    = '0;
      req_bus.line      = '0;
      rsp_bus.ready     = 1'b0;
      mismatch_count    = 0;
      hold_requests     = 0;
      burst_col         = '0;
      burst_line        = '0;
      attr_image        = RESET_ATTR;
      wipe_screen();

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed part, reset attribute
      queue_cmd(CMD_READ, 8'h00, 0, 0);
      queue_cmd(CMD_PUT, 8'h41, 0, 0);
      queue_cmd(CMD_PUT, 8'hFF, 0, 0);
      queue_cmd(CMD_PUT, 8'h00, 0, 0);
      queue_cmd(CMD_READ, 8'h00, 0, 0);
      queue_cmd(CMD_PUT, CH_TAB, 0, 0);
      queue_cmd(CMD_PUT, CH_BACKSPACE, 0, 0);
      queue_cmd(CMD_PUT, CH_RETURN, 0, 0);
      queue_cmd(CMD_PUT, CH_BACKSPACE, 0, 0);     // ignored at the origin
      queue_cmd(CMD_PUT, CH_NEWLINE, 0, 0);
      queue_cmd(CMD_SET, 8'h00, 127, 31);         // saturates to the last cell
      queue_cmd(CMD_PUT, 8'h5A, 0, 0);            // cursor now at end of screen
      queue_cmd(CMD_PUT, CH_RETURN, 0, 0);        // stays at end of screen
      queue_cmd(CMD_PUT, 8'h42, 0, 0);            // scrolls before writing
      queue_cmd(CMD_READ, 8'h00, 0, 24);
      queue_cmd(CMD_SET, 8'h00, 79, 24);
      queue_cmd(CMD_PUT, CH_TAB, 0, 0);           // fills the last cell only
      queue_cmd(CMD_PUT, CH_TAB, 0, 0);           // scrolls, then a full tab
      queue_cmd(CMD_PUT, CH_NEWLINE, 0, 0);       // bottom row, scrolls again
      queue_cmd(CMD_SET, 8'hFF, 127, 24);
      queue_cmd(CMD_PUT, 8'h7E, 0, 0);
      queue_cmd(CMD_PUT, CH_NEWLINE, 127, 31);    // newline from end of screen
      queue_cmd(CMD_READ, 8'hFF, 127, 31);
      queue_cmd(CMD_CLEAR, 8'hFF, 127, 31);
      queue_cmd(CMD_READ, 8'h00, 0, 23);

      phase_attr[0] = ZERO_ATTR;
      phase_attr[1] = 8'hFF;
      phase_attr[2] = 8'h1E;
      phase_attr[3] = ATTR_W'($urandom);
      phase_attr[4] = ATTR_W'($urandom);
      phase_attr[5] = RESET_ATTR;
      for (int p = 0; p < 6; p++) begin
         set_text_attribute(phase_attr[p]);
         if (p == 1 || p == 4) hold_requests++;
         while (cmd_backlog.size() < PHASE_WORDS) queue_random_burst();
      end

      wait_console_idle();
      repeat (40) @(posedge clock);
      if (expected_replies.size() != 0) begin
         mismatch_count++;
         $error("%0d replies never arrived", expected_replies.size());
      end
      if (mismatch_count == 0)
         $display("text_console_cell_writer verification clean");
      else
         $display("text_console_cell_writer verification failed");
      $finish;
   end

endmodule
